// ===== rtl/ltc_pkg.sv =====
package ltc_pkg;

    // Configuration port
    localparam int CFG_AW         = 5;
    localparam int CFG_DW         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int MAX_DRIVES     = 2;
    localparam int DRV_W          = 1;
    localparam int REGS_PER_DRIVE = 3;
    localparam int FLD_SPT        = 0;
    localparam int FLD_HEADS      = 1;
    localparam int FLD_CYL        = 2;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_HEADS = 2'd2;

    // Task-file constants
    localparam logic [7:0] DEV_HEAD_BASE  = 8'hA0;
    localparam logic [7:0] MAX_HEADS      = 8'd16;
    localparam logic [7:0] CTL_HEAD_LIMIT = 8'd8;
    localparam logic [3:0] CTL_VALUE      = 4'd8;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Divider shapes: block / spt, then track / heads
    localparam int BLOCK_W    = 32;
    localparam int SPT_W      = 8;
    localparam int TRACK_W    = 20;
    localparam int HEAD_DVS_W = 5;
    localparam int DIV_BPS    = 4;

    // Classified request handed from front to back
    typedef struct packed {
        t_status               status;
        logic                  unit;
        logic [BLOCK_W-1:0]    block;
        logic [7:0]            count;
        logic                  wr;
        logic [SPT_W-1:0]      spt;
        logic [7:0]            heads;
    } t_req;

    // Sideband through the sector divider
    typedef struct packed {
        t_status               status;
        logic                  unit;
        logic [7:0]            heads;
        logic [7:0]            count;
        logic                  wr;
    } t_side1;

    // Sideband through the head divider
    typedef struct packed {
        t_status               status;
        logic                  unit;
        logic                  ctl;
        logic [7:0]            count;
        logic                  wr;
        logic [7:0]            sec;
    } t_side2;

endpackage

// ===== rtl/lba_to_chs_request_translator_unit.sv =====
// Channel     | Direction | Handshake                       | Payload
// ------------+-----------+---------------------------------+------------------------------
// request     | in        | push / full                     | drive unit, start block,
//             |           |                                 | sector count, cmd
// result      | out       | empty / pop                     | status, sector, head, cylinder,
//             |           |                                 | dev/head, control, count, write
// config      | in        | APB psel/penable/pwrite, pready | six geometry regs at 4*i
//
// One transaction per cycle sustained while neither side stalls; a request passes through
// two front stages, one queue slot, 8 sector-divider and 5 head-divider stages
// (4 quotient bits a stage each), and the result register before it can be popped.
// Reset is synchronous and active low; geometry clears to zero, so every request is
// out of range until the drive is configured.
// The front stalls only when the 4-entry queue is full; the back stalls as a whole
// while a result waits unpopped.
module lba_to_chs_request_translator_unit
    import ltc_pkg::*;
#(
    parameter int NUM_DRIVES = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // request queue side
    input  logic              push,
    output logic              full,
    input  logic              i_drive_unit,
    input  logic [31:0]       i_start_block,
    input  logic [7:0]        i_sector_count,
    input  logic              i_cmd,
    // result queue side
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_status,
    output logic [7:0]        o_sector_number,
    output logic [3:0]        o_head_number,
    output logic [15:0]       o_cylinder_number,
    output logic [7:0]        o_device_head_byte,
    output logic [3:0]        o_control_byte,
    output logic [7:0]        o_count_byte,
    output logic              o_is_write
);

    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 front_valid;
    t_req                 front_req;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    t_req                 q_req;

    // zero-wait APB: the write lands in the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_AW-1:2];

    // front: register file, geometry lookup, range and head checks
    ltc_front #(
        .NUM_DRIVES (NUM_DRIVES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (pwdata),
        .o_cfg_rdata    (prdata),
        .i_push         (push),
        .i_drive_unit   (i_drive_unit),
        .i_start_block  (i_start_block),
        .i_sector_count (i_sector_count),
        .i_cmd          (i_cmd),
        .o_full         (full),
        .o_valid        (front_valid),
        .o_req          (front_req),
        .i_q_full       (q_full)
    );

    // decouples classification from the divider pipelines
    ltc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_req),
        .o_empty (q_empty)
    );

    // back: two pipelined dividers and the task-file bytes
    ltc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_req              (q_req),
        .o_q_pop            (q_pop),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_status           (o_status),
        .o_sector_number    (o_sector_number),
        .o_head_number      (o_head_number),
        .o_cylinder_number  (o_cylinder_number),
        .o_device_head_byte (o_device_head_byte),
        .o_control_byte     (o_control_byte),
        .o_count_byte       (o_count_byte),
        .o_is_write         (o_is_write)
    );

endmodule

// ===== rtl/ltc_queue.sv =====
module ltc_queue
    import ltc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output t_req o_data,
    output logic o_empty
);

    t_req              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/ltc_front.sv =====
module ltc_front
    import ltc_pkg::*;
#(
    parameter int NUM_DRIVES = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_wdata,
    output logic [CFG_DW-1:0]    o_cfg_rdata,
    // requests in
    input  logic                 i_push,
    input  logic                 i_drive_unit,
    input  logic [BLOCK_W-1:0]   i_start_block,
    input  logic [7:0]           i_sector_count,
    input  logic                 i_cmd,
    output logic                 o_full,
    // classified requests out
    output logic                 o_valid,
    output t_req                 o_req,
    input  logic                 i_q_full
);

    logic [SPT_W-1:0] r_spt   [MAX_DRIVES];
    logic [7:0]       r_heads [MAX_DRIVES];
    logic [15:0]      r_cyl   [MAX_DRIVES];

    // stage A: geometry looked up, heads * spt
    logic               r_a_valid;
    logic               r_a_unit;
    logic [BLOCK_W-1:0] r_a_block;
    logic [7:0]         r_a_count;
    logic               r_a_wr;
    logic [SPT_W-1:0]   r_a_spt;
    logic [7:0]         r_a_heads;
    logic [15:0]        r_a_cyl;
    logic [15:0]        r_a_hs;

    // stage B: capacity
    logic               r_b_valid;
    logic               r_b_unit;
    logic [BLOCK_W-1:0] r_b_block;
    logic [7:0]         r_b_count;
    logic               r_b_wr;
    logic [SPT_W-1:0]   r_b_spt;
    logic [7:0]         r_b_heads;
    logic [31:0]        r_b_cap;

    logic               adv;
    logic               accept;
    logic [DRV_W-1:0]   sel;
    logic [32:0]        req_end;
    logic               out_of_range;
    t_status            status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DRIVES; d++) begin
                r_spt[d]   <= '0;
                r_heads[d] <= '0;
                r_cyl[d]   <= '0;
            end
        end else if (i_cfg_wr) begin
            for (int d = 0; d < MAX_DRIVES; d++) begin
                if (d < NUM_DRIVES) begin
                    if (i_cfg_idx == CFG_IDX_W'(d*REGS_PER_DRIVE + FLD_SPT)) begin
                        r_spt[d] <= i_cfg_wdata[SPT_W-1:0];
                    end
                    if (i_cfg_idx == CFG_IDX_W'(d*REGS_PER_DRIVE + FLD_HEADS)) begin
                        r_heads[d] <= i_cfg_wdata[7:0];
                    end
                    if (i_cfg_idx == CFG_IDX_W'(d*REGS_PER_DRIVE + FLD_CYL)) begin
                        r_cyl[d] <= i_cfg_wdata[15:0];
                    end
                end
            end
        end
    end

    always_comb begin
        o_cfg_rdata = '0;
        for (int d = 0; d < MAX_DRIVES; d++) begin
            if (d < NUM_DRIVES) begin
                if (i_cfg_idx == CFG_IDX_W'(d*REGS_PER_DRIVE + FLD_SPT)) begin
                    o_cfg_rdata = CFG_DW'(r_spt[d]);
                end
                if (i_cfg_idx == CFG_IDX_W'(d*REGS_PER_DRIVE + FLD_HEADS)) begin
                    o_cfg_rdata = CFG_DW'(r_heads[d]);
                end
                if (i_cfg_idx == CFG_IDX_W'(d*REGS_PER_DRIVE + FLD_CYL)) begin
                    o_cfg_rdata = CFG_DW'(r_cyl[d]);
                end
            end
        end
    end

    // whole front moves together; it stalls only when stage B cannot drain
    assign adv    = !r_b_valid || !i_q_full;
    assign o_full = !adv;
    assign accept = i_push && adv;
    assign sel    = i_drive_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_unit  <= i_drive_unit;
            r_a_block <= i_start_block;
            r_a_count <= i_sector_count;
            r_a_wr    <= i_cmd;
            r_a_spt   <= r_spt[sel];
            r_a_heads <= r_heads[sel];
            r_a_cyl   <= r_cyl[sel];
            r_a_hs    <= r_heads[sel] * r_spt[sel];

            r_b_unit  <= r_a_unit;
            r_b_block <= r_a_block;
            r_b_count <= r_a_count;
            r_b_wr    <= r_a_wr;
            r_b_spt   <= r_a_spt;
            r_b_heads <= r_a_heads;
            r_b_cap   <= r_a_hs * r_a_cyl;
        end
    end

    // range check first, then head limit
    assign req_end      = {1'b0, r_b_block} + 33'(r_b_count);
    assign out_of_range = ({31'b0, r_b_unit} >= 32'(NUM_DRIVES))
                          || (r_b_block >= r_b_cap)
                          || (req_end > {1'b0, r_b_cap});

    always_comb begin
        priority if (out_of_range) begin
            status = ST_RANGE;
        end else if (r_b_heads > MAX_HEADS) begin
            status = ST_HEADS;
        end else begin
            status = ST_OK;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_req.status  = status;
    assign o_req.unit    = r_b_unit;
    assign o_req.block   = r_b_block;
    assign o_req.count   = r_b_count;
    assign o_req.wr      = r_b_wr;
    assign o_req.spt     = r_b_spt;
    assign o_req.heads   = r_b_heads;

endmodule

// ===== rtl/ltc_div_pipe.sv =====
module ltc_div_pipe
    import ltc_pkg::*;
#(
    parameter int  DW  = 32,
    parameter int  VW  = 8,
    parameter int  BPS = 4,
    parameter type t_side = logic
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder,
    output t_side         o_side
);

    localparam int STAGES = DW / BPS;

    logic          r_valid [STAGES];
    logic [VW-1:0] r_rem   [STAGES];
    logic [DW-1:0] r_quo   [STAGES];
    logic [VW-1:0] r_dvs   [STAGES];
    t_side         r_side  [STAGES];

    // r_quo shifts dividend bits out at the top and quotient bits in at the bottom
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic          in_valid;
        logic [VW-1:0] in_rem;
        logic [DW-1:0] in_quo;
        logic [VW-1:0] in_dvs;
        t_side         in_side;
        logic [VW-1:0] n_rem;
        logic [DW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_rem   = '0;
            assign in_quo   = i_dividend;
            assign in_dvs   = i_divisor;
            assign in_side  = i_side;
        end else begin : g_next
            assign in_valid = r_valid[s-1];
            assign in_rem   = r_rem[s-1];
            assign in_quo   = r_quo[s-1];
            assign in_dvs   = r_dvs[s-1];
            assign in_side  = r_side[s-1];
        end

        always_comb begin
            logic [VW:0]   trial;
            logic [VW-1:0] rem;
            logic [DW-1:0] quo;
            rem = in_rem;
            quo = in_quo;
            for (int b = 0; b < BPS; b++) begin
                trial = {rem, quo[DW-1]};
                quo   = {quo[DW-2:0], 1'b0};
                if (trial >= {1'b0, in_dvs}) begin
                    trial  = trial - {1'b0, in_dvs};
                    quo[0] = 1'b1;
                end
                rem = trial[VW-1:0];
            end
            n_rem = rem;
            n_quo = quo;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_dvs[s]  <= in_dvs;
                r_side[s] <= in_side;
            end
        end
    end

    assign o_valid     = r_valid[STAGES-1];
    assign o_quotient  = r_quo[STAGES-1];
    assign o_remainder = r_rem[STAGES-1];
    assign o_side      = r_side[STAGES-1];

endmodule

// ===== rtl/ltc_back.sv =====
module ltc_back
    import ltc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // classified requests from the queue
    input  logic        i_q_empty,
    input  t_req        i_req,
    output logic        o_q_pop,
    // results
    output logic        o_empty,
    input  logic        i_pop,
    output t_status     o_status,
    output logic [7:0]  o_sector_number,
    output logic [3:0]  o_head_number,
    output logic [15:0] o_cylinder_number,
    output logic [7:0]  o_device_head_byte,
    output logic [3:0]  o_control_byte,
    output logic [7:0]  o_count_byte,
    output logic        o_is_write
);

    logic                  adv;
    t_side1                side1_in;
    logic                  d1_valid;
    logic [BLOCK_W-1:0]    d1_quo;
    logic [SPT_W-1:0]      d1_rem;
    t_side1                d1_side;
    t_side2                side2_in;
    logic                  d2_valid;
    logic [TRACK_W-1:0]    d2_quo;
    logic [HEAD_DVS_W-1:0] d2_rem;
    t_side2                d2_side;
    logic                  ok;
    logic [3:0]            head;

    logic                  r_out_valid;
    t_status               r_status;
    logic [7:0]            r_sec;
    logic [3:0]            r_head;
    logic [15:0]           r_cyl;
    logic                  r_unit;
    logic                  r_ctl;
    logic [7:0]            r_count;
    logic                  r_wr;

    assign adv     = !r_out_valid || i_pop;
    assign o_q_pop = adv && !i_q_empty;

    assign side1_in.status = i_req.status;
    assign side1_in.unit   = i_req.unit;
    assign side1_in.heads  = i_req.heads;
    assign side1_in.count  = i_req.count;
    assign side1_in.wr     = i_req.wr;

    // block / spt -> track, sector - 1
    ltc_div_pipe #(
        .DW     (BLOCK_W),
        .VW     (SPT_W),
        .BPS    (DIV_BPS),
        .t_side (t_side1)
    ) u_sec_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_valid     (!i_q_empty),
        .i_dividend  (i_req.block),
        .i_divisor   (i_req.spt),
        .i_side      (side1_in),
        .o_valid     (d1_valid),
        .o_quotient  (d1_quo),
        .o_remainder (d1_rem),
        .o_side      (d1_side)
    );

    assign side2_in.status = d1_side.status;
    assign side2_in.unit   = d1_side.unit;
    assign side2_in.ctl    = (d1_side.heads > CTL_HEAD_LIMIT);
    assign side2_in.count  = d1_side.count;
    assign side2_in.wr     = d1_side.wr;
    assign side2_in.sec    = d1_rem + 8'd1;

    // track / heads -> cylinder, head; an accepted track stays below 2^20
    ltc_div_pipe #(
        .DW     (TRACK_W),
        .VW     (HEAD_DVS_W),
        .BPS    (DIV_BPS),
        .t_side (t_side2)
    ) u_head_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_valid     (d1_valid),
        .i_dividend  (d1_quo[TRACK_W-1:0]),
        .i_divisor   (d1_side.heads[HEAD_DVS_W-1:0]),
        .i_side      (side2_in),
        .o_valid     (d2_valid),
        .o_quotient  (d2_quo),
        .o_remainder (d2_rem),
        .o_side      (d2_side)
    );

    assign ok   = (d2_side.status == ST_OK);
    assign head = ok ? d2_rem[3:0] : 4'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= d2_side.status;
            r_sec    <= ok ? d2_side.sec : 8'd0;
            r_head   <= head;
            r_cyl    <= ok ? d2_quo[15:0] : 16'd0;
            r_unit   <= d2_side.unit;
            r_ctl    <= d2_side.ctl;
            r_count  <= d2_side.count;
            r_wr     <= d2_side.wr;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_status           = r_status;
    assign o_sector_number    = r_sec;
    assign o_head_number      = r_head;
    assign o_cylinder_number  = r_cyl;
    assign o_device_head_byte = DEV_HEAD_BASE | {3'b000, r_unit, r_head};
    assign o_control_byte     = r_ctl ? CTL_VALUE : 4'd0;
    assign o_count_byte       = r_count;
    assign o_is_write         = r_wr;

endmodule

// ===== tb/chs_translation_checker.sv =====
module chs_translation_checker
    import ltc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    input  logic              i_pready,
    input  logic              i_push,
    input  logic              i_full,
    input  logic              i_drive_unit,
    input  logic [31:0]       i_start_block,
    input  logic [7:0]        i_sector_count,
    input  logic              i_cmd,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [1:0]        i_status,
    input  logic [7:0]        i_sector_number,
    input  logic [3:0]        i_head_number,
    input  logic [15:0]       i_cylinder_number,
    input  logic [7:0]        i_device_head_byte,
    input  logic [3:0]        i_control_byte,
    input  logic [7:0]        i_count_byte,
    input  logic              i_is_write,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [7:0]  sector;
        logic [3:0]  head;
        logic [15:0] cyl;
        logic [7:0]  dev_head;
        logic [3:0]  ctl;
        logic [7:0]  count;
        logic        wr;
    } t_chs_result;

    logic [7:0]  geo_spt   [MAX_DRIVES];
    logic [7:0]  geo_heads [MAX_DRIVES];
    logic [15:0] geo_cyl   [MAX_DRIVES];

    t_chs_result pending_translations[$];
    int          mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatch_total++;
    endtask

    function automatic t_chs_result translate_lba(input logic unit, input logic [31:0] block,
                                                  input logic [7:0] count, input logic wr);
        t_chs_result r;
        logic [63:0] cap;
        logic [63:0] track;
        logic [7:0]  spt;
        logic [7:0]  heads;
        logic [15:0] cyls;
        spt   = geo_spt[unit];
        heads = geo_heads[unit];
        cyls  = geo_cyl[unit];
        cap   = 64'(heads) * 64'(spt) * 64'(cyls);
        r = '0;
        r.status = ST_OK;
        // range is checked first, so zero geometry always lands here
        if (64'(block) >= cap || 64'(block) + 64'(count) > cap) begin
            r.status = ST_RANGE;
        end else if (heads > MAX_HEADS) begin
            r.status = ST_HEADS;
        end else begin
            track    = 64'(block) / 64'(spt);
            r.sector = 8'(64'(block) % 64'(spt) + 64'd1);
            r.head   = 4'(track % 64'(heads));
            r.cyl    = 16'(track / 64'(heads));
        end
        r.dev_head = DEV_HEAD_BASE | {3'b000, unit, 4'h0} | {4'h0, r.head};
        r.ctl      = (heads > CTL_HEAD_LIMIT) ? CTL_VALUE : 4'd0;
        r.count    = count;
        r.wr       = wr;
        return r;
    endfunction

    always @(posedge i_clk) begin
        int          idx;
        int          drv;
        t_chs_result want;
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DRIVES; d++) begin
                geo_spt[d]   = '0;
                geo_heads[d] = '0;
                geo_cyl[d]   = '0;
            end
            pending_translations.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = int'(i_paddr) / 4;
                drv = idx / REGS_PER_DRIVE;
                if (drv < MAX_DRIVES) begin
                    case (idx % REGS_PER_DRIVE)
                        FLD_SPT:   geo_spt[drv]   = i_pwdata[7:0];
                        FLD_HEADS: geo_heads[drv] = i_pwdata[7:0];
                        FLD_CYL:   geo_cyl[drv]   = i_pwdata[15:0];
                        default: ;
                    endcase
                end
            end
            if (i_push && !i_full)
                pending_translations.push_back(translate_lba(i_drive_unit, i_start_block,
                                                             i_sector_count, i_cmd));
            if (i_pop && !i_empty) begin
                if (pending_translations.size() == 0) begin
                    report_mismatch("unexpected result, status", 32'(i_status), 32'd0);
                end else begin
                    want = pending_translations.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", 32'(i_status), 32'(want.status));
                    if (i_sector_number !== want.sector)
                        report_mismatch("sector", 32'(i_sector_number), 32'(want.sector));
                    if (i_head_number !== want.head)
                        report_mismatch("head", 32'(i_head_number), 32'(want.head));
                    if (i_cylinder_number !== want.cyl)
                        report_mismatch("cylinder", 32'(i_cylinder_number), 32'(want.cyl));
                    if (i_device_head_byte !== want.dev_head)
                        report_mismatch("dev/head", 32'(i_device_head_byte),
                                        32'(want.dev_head));
                    if (i_control_byte !== want.ctl)
                        report_mismatch("control", 32'(i_control_byte), 32'(want.ctl));
                    if (i_count_byte !== want.count)
                        report_mismatch("count", 32'(i_count_byte), 32'(want.count));
                    if (i_is_write !== want.wr)
                        report_mismatch("is_write", 32'(i_is_write), 32'(want.wr));
                end
            end
        end
        o_pending <= pending_translations.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench
    import ltc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // DUT-facing signals
    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              push;
    logic              full;
    logic              i_drive_unit;
    logic [31:0]       i_start_block;
    logic [7:0]        i_sector_count;
    logic              i_cmd;
    logic              empty;
    logic              pop;
    logic [1:0]        o_status;
    logic [7:0]        o_sector_number;
    logic [3:0]        o_head_number;
    logic [15:0]       o_cylinder_number;
    logic [7:0]        o_device_head_byte;
    logic [3:0]        o_control_byte;
    logic [7:0]        o_count_byte;
    logic              o_is_write;

    int fail_count;
    int pending;

    // per-phase idling, percent of cycles
    int send_idle_pct = 0;
    int pop_stall_pct = 0;

    // stimulus-side copy of the geometry, only used to aim blocks inside and near capacity
    logic [7:0]  g_spt   [MAX_DRIVES];
    logic [7:0]  g_heads [MAX_DRIVES];
    logic [15:0] g_cyl   [MAX_DRIVES];

    lba_to_chs_request_translator_unit #(.NUM_DRIVES(2)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .push               (push),
        .full               (full),
        .i_drive_unit       (i_drive_unit),
        .i_start_block      (i_start_block),
        .i_sector_count     (i_sector_count),
        .i_cmd              (i_cmd),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_sector_number    (o_sector_number),
        .o_head_number      (o_head_number),
        .o_cylinder_number  (o_cylinder_number),
        .o_device_head_byte (o_device_head_byte),
        .o_control_byte     (o_control_byte),
        .o_count_byte       (o_count_byte),
        .o_is_write         (o_is_write)
    );

    chs_translation_checker i_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .i_push             (push),
        .i_full             (full),
        .i_drive_unit       (i_drive_unit),
        .i_start_block      (i_start_block),
        .i_sector_count     (i_sector_count),
        .i_cmd              (i_cmd),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_status           (o_status),
        .i_sector_number    (o_sector_number),
        .i_head_number      (o_head_number),
        .i_cylinder_number  (o_cylinder_number),
        .i_device_head_byte (o_device_head_byte),
        .i_control_byte     (o_control_byte),
        .i_count_byte       (o_count_byte),
        .i_is_write         (o_is_write),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: pop is rerolled every cycle; while empty it just does nothing.
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            pop <= ($urandom_range(0, 99) >= pop_stall_pct);
        end
    end

    // Hard stop.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One request transaction. Optional idle cycles first, then push held
    // until the edge where full is low. push stays high on return so
    // back-to-back transactions need no bubble.
    task automatic send_request(input logic unit, input logic [31:0] block,
                                input logic [7:0] count, input logic wr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_drive_unit   <= unit;
        i_start_block  <= block;
        i_sector_count <= count;
        i_cmd          <= wr;
        do @(posedge i_clk); while (full);
    endtask

    // APB write: setup, access (waits on pready), then the bus goes idle before return so
    // psel never gets two updates in the same step.
    task automatic write_register(input int idx, input logic [CFG_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_geometry(input int drv, input logic [7:0] spt,
                                  input logic [7:0] heads, input logic [15:0] cyl);
        write_register(drv * REGS_PER_DRIVE + FLD_SPT, CFG_DW'(spt));
        write_register(drv * REGS_PER_DRIVE + FLD_HEADS, CFG_DW'(heads));
        write_register(drv * REGS_PER_DRIVE + FLD_CYL, CFG_DW'(cyl));
        g_spt[drv]   = spt;
        g_heads[drv] = heads;
        g_cyl[drv]   = cyl;
    endtask

    // Sender holds off until every expected result is back, then lets the
    // pipeline settle before anything touches config.
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (24) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic        unit;
        logic [31:0] block;
        logic [7:0]  count;
        logic [63:0] cap;
        logic [7:0]  spt;
        logic [7:0]  heads;
        logic [15:0] cyl;
        int          roll;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        push           = 1'b0;
        i_drive_unit   = 1'b0;
        i_start_block  = '0;
        i_sector_count = '0;
        i_cmd          = 1'b0;
        for (int d = 0; d < MAX_DRIVES; d++) begin
            g_spt[d]   = '0;
            g_heads[d] = '0;
            g_cyl[d]   = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // reset geometry is all zero: capacity 0, everything out of range
        send_request(1'b0, 32'd0, 8'd0, 1'b0);
        send_request(1'b1, 32'hFFFF_FFFF, 8'd255, 1'b1);
        wait_drained();

        // drive 0: 63 spt x 16 heads x 1024 cyl (cap 1032192)
        // drive 1: all-max geometry, 255 heads -> too many heads when in range
        write_geometry(0, 8'd63, 8'd16, 16'd1024);
        write_geometry(1, 8'd255, 8'd255, 16'd65535);
        send_request(1'b0, 32'd0, 8'd0, 1'b0);
        send_request(1'b0, 32'd62, 8'd1, 1'b0);       // last sector of first track
        send_request(1'b0, 32'd63, 8'd1, 1'b1);       // head wraps to 1
        send_request(1'b0, 32'd1008, 8'd1, 1'b0);     // first block of cylinder 1
        send_request(1'b0, 32'd1032191, 8'd1, 1'b1);  // last block, fits exactly
        send_request(1'b0, 32'd1032191, 8'd2, 1'b0);  // runs one past the end
        send_request(1'b0, 32'd1032192, 8'd0, 1'b1);  // block at capacity
        send_request(1'b0, 32'd1000, 8'd255, 1'b1);
        send_request(1'b1, 32'd0, 8'd0, 1'b0);        // in range, heads rejected
        send_request(1'b1, 32'd4261413374, 8'd1, 1'b1);
        send_request(1'b1, 32'hFFFF_FFFF, 8'd255, 1'b0); // range wins over heads
        send_request(1'b1, 32'd4261413375, 8'd0, 1'b1);
        wait_drained();

        // tiny geometries: 8 heads gives control 0, 9 heads gives control 8
        write_geometry(0, 8'd1, 8'd8, 16'd1);
        write_geometry(1, 8'd2, 8'd9, 16'd3);
        send_request(1'b0, 32'd0, 8'd0, 1'b0);
        send_request(1'b0, 32'd0, 8'd1, 1'b1);
        send_request(1'b0, 32'd7, 8'd1, 1'b0);        // head 7
        send_request(1'b0, 32'd8, 8'd0, 1'b1);
        send_request(1'b0, 32'd0, 8'd255, 1'b0);
        send_request(1'b1, 32'd53, 8'd1, 1'b1);       // head 8, cyl 2, sector 2

        // ---- random phases ----
        // Each phase: drain, new geometry on both drives, then one idling mode:
        // none / sender 88% idle / receiver 88% stalled / both 22%.
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 88; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 88; end
                default: begin send_idle_pct = 22; pop_stall_pct = 22; end
            endcase
            for (int d = 0; d < MAX_DRIVES; d++) begin
                roll = $urandom_range(0, 99);
                spt = (roll < 8) ? 8'd1 : (roll < 16) ? 8'd255 : (roll < 19) ? 8'd0 :
                      8'($urandom_range(1, 255));
                roll = $urandom_range(0, 99);
                heads = (roll < 3) ? 8'd0 : (roll < 15) ? 8'($urandom_range(17, 255)) :
                        (roll < 25) ? 8'd16 : (roll < 35) ? 8'($urandom_range(8, 9)) :
                        8'($urandom_range(1, 16));
                roll = $urandom_range(0, 99);
                cyl = (roll < 10) ? 16'd1 : (roll < 20) ? 16'd65535 : (roll < 23) ? 16'd0 :
                      16'($urandom_range(1, 65535));
                write_geometry(d, spt, heads, cyl);
            end
            repeat (116) begin
                unit = 1'($urandom_range(0, 1));
                cap  = 64'(g_heads[unit]) * 64'(g_spt[unit]) * 64'(g_cyl[unit]);
                roll = $urandom_range(0, 99);
                if (roll < 75 && cap != 0) begin
                    // mostly well-formed: start inside the drive, transfer fits
                    block = 32'(64'($urandom) % cap);
                    count = 8'($urandom_range(0, 255));
                    if (64'(block) + 64'(count) > cap)
                        count = 8'(cap - 64'(block));
                end else if (roll < 88) begin
                    // hug the end of the drive, both sides of the boundary
                    block = (cap >= 5) ? 32'(cap - 64'($urandom_range(0, 4))) :
                            32'($urandom_range(0, 4));
                    count = 8'($urandom_range(0, 6));
                end else begin
                    block = $urandom;
                    count = 8'($urandom_range(0, 255));
                end
                send_request(unit, block, count, 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ltc_pkg.sv
rtl/ltc_queue.sv
rtl/ltc_front.sv
rtl/ltc_div_pipe.sv
rtl/ltc_back.sv
rtl/lba_to_chs_request_translator_unit.sv
tb/chs_translation_checker.sv
tb/testbench.sv
